### hw/rtl/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants of the Fresnel reflectance pipeline
// Fixed-point formats, unit widths and the payload that travels with an item.
// ----------------------------------------------------------------------------
package fdr_pkg;

    // Fraction bits of the input vector components.
    localparam int COMPONENT_FRACTION_BITS = 15;
    localparam int TWO_F = 2 * COMPONENT_FRACTION_BITS;

    // Dot product value of one, and the shifts that bring the cosine to Q30.
    localparam logic [63:0] ONE_DOT = 64'(1) << TWO_F;
    localparam int SH_R = (TWO_F >= 30) ? TWO_F - 30 : 0;
    localparam int SH_L = (TWO_F < 30) ? 30 - TWO_F : 0;

    localparam int IDX_W   = 16;                // Q2.14 refraction index
    localparam int COS_W   = 31;                // Q30 value up to one
    localparam int RAD_W   = 61;                // radicand up to 2^60
    localparam int ROOT_W  = 31;
    localparam int ISQ_RW  = RAD_W + 1;         // working width of the root
    localparam int ISQ_STAGES = RAD_W / 2 + 1;
    localparam int DIV_W   = 35;                // divisor and remainder width
    localparam int DIV_Q   = 30;                // quotient bits
    localparam int NUM_W   = IDX_W + COS_W;     // index times Q30 value
    localparam int TERM_W  = 32;                // Q30 terms after the >> 14
    localparam int SQ_W    = 2 * COS_W - 1;     // square of a value up to 2^30
    localparam int REFL_W  = 17;

    localparam logic [RAD_W-1:0]  ONE_SQ   = RAD_W'(1) << 60;
    localparam logic [COS_W-1:0]  Q30_ONE  = COS_W'(1) << 30;
    localparam logic [REFL_W-1:0] REFL_ONE = REFL_W'(65536);
    localparam logic [IDX_W-1:0]  OUTER_RST = 16'd16384;
    localparam logic [IDX_W-1:0]  INNER_RST = 16'd24576;

    typedef enum logic [0:0] {
        CFG_OUTER = 1'b0,
        CFG_INNER = 1'b1
    } cfg_idx_t;

    // Sideband carried alongside an item through the arithmetic units.
    typedef struct packed {
        logic [IDX_W-1:0] n1;
        logic [IDX_W-1:0] n2;
        logic [COS_W-1:0] c;
        logic             tir;
        logic             rs_full;
        logic             rp_full;
    } ray_t;

    typedef struct packed {
        logic              tir;
        logic [IDX_W-1:0]  n2;
        logic [IDX_W-1:0]  n1;
        logic [REFL_W-1:0] refl;
    } res_t;

endpackage

### hw/rtl/fresnel_dielectric_reflectance_top.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_top: unpolarized dielectric Fresnel reflectance
// Dot product, Snell quotient, two square roots and two amplitude ratios.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the 135-stage pipeline advances as one.
// The pipeline holds while its two-entry output buffer is full.
// Reset clears all valid bits and the buffer, and loads outer_index with 1.0
// and inner_index with 1.5.
module fresnel_dielectric_reflectance_top
    import fdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // reflectance, incident_index, transmitted_index, zero fill
    output logic        m_tuser,   // total_internal_reflection
    input  logic        cfg_wen,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [IDX_W-1:0] outer_reg, inner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg <= OUTER_RST;
            inner_reg <= INNER_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OUTER: outer_reg <= cfg_wdata;
                CFG_INNER: inner_reg <= cfg_wdata;
                default:   outer_reg <= outer_reg;
            endcase
        end
    end

    logic       en;
    logic [1:0] cnt_reg;

    assign en       = cnt_reg != 2'd2;
    assign s_tready = en;

    // Front end: cosine and 1 - c^2.
    logic             f_vld;
    logic [RAD_W-1:0] f_rad;
    ray_t             f_side;

    fdr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .vld_in      (s_tvalid && en),
        .ix          (s_tdata[15:0]),
        .iy          (s_tdata[31:16]),
        .iz          (s_tdata[47:32]),
        .nx          (s_tdata[63:48]),
        .ny          (s_tdata[79:64]),
        .nz          (s_tdata[95:80]),
        .outer_index (outer_reg),
        .inner_index (inner_reg),
        .vld_out     (f_vld),
        .rad_out     (f_rad),
        .side_out    (f_side)
    );

    logic              q1_vld;
    logic [ROOT_W-1:0] sin_i;
    ray_t              q1_side;

    fdr_isqrt u_sqrt_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (f_vld),
        .rad_in   (f_rad),
        .side_in  (f_side),
        .vld_out  (q1_vld),
        .root_out (sin_i),
        .side_out (q1_side)
    );

    // Snell quotient n1 * sin_i / n2; TIR is decided from the top bits.
    logic             m1_vld_reg, m2_vld_reg;
    logic [NUM_W-1:0] m1_num_reg;
    ray_t             m1_side_reg, m2_side_reg;
    logic [DIV_W-1:0] m2_rem_reg, m2_dv_reg;
    logic [DIV_Q-1:0] m2_low_reg;
    logic [NUM_W-DIV_Q-1:0] num_hi;
    ray_t             m2_side_next;

    always_comb
    begin
        num_hi           = m1_num_reg[NUM_W-1:DIV_Q];
        m2_side_next     = m1_side_reg;
        m2_side_next.tir = (num_hi >= (NUM_W-DIV_Q)'(m1_side_reg.n2))
                           || (m1_side_reg.n2 == '0);
    end

    logic             d1_vld;
    logic [DIV_Q-1:0] sin_t;
    ray_t             d1_side;

    fdr_div u_div_snell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (m2_vld_reg),
        .rem_in   (m2_rem_reg),
        .low_in   (m2_low_reg),
        .dvsr_in  (m2_dv_reg),
        .side_in  (m2_side_reg),
        .vld_out  (d1_vld),
        .quo_out  (sin_t),
        .side_out (d1_side)
    );

    logic             m3_vld_reg, m4_vld_reg;
    logic [SQ_W-1:0]  m3_sq_reg;
    logic [RAD_W-1:0] m4_rad_reg;
    ray_t             m3_side_reg, m4_side_reg;

    logic              q2_vld;
    logic [ROOT_W-1:0] cos_t;
    ray_t              q2_side;

    fdr_isqrt u_sqrt_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (m4_vld_reg),
        .rad_in   (m4_rad_reg),
        .side_in  (m4_side_reg),
        .vld_out  (q2_vld),
        .root_out (cos_t),
        .side_out (q2_side)
    );

    // Amplitude ratio terms in Q30.
    logic              b1_vld_reg, b2_vld_reg;
    logic [TERM_W-1:0] a_reg, b_reg, a2_reg, b2_reg;
    ray_t              b1_side_reg, b2_side_reg;
    logic [TERM_W:0]   ds_reg, ss_reg, dp_reg, sp_reg;
    logic [TERM_W:0]   ds, ss, dp, sp;
    ray_t              b2_side_next;

    always_comb
    begin
        ds = (a_reg > b_reg) ? {1'b0, a_reg - b_reg} : {1'b0, b_reg - a_reg};
        ss = {1'b0, a_reg} + {1'b0, b_reg};
        dp = (a2_reg > b2_reg) ? {1'b0, a2_reg - b2_reg} : {1'b0, b2_reg - a2_reg};
        sp = {1'b0, a2_reg} + {1'b0, b2_reg};
        b2_side_next         = b1_side_reg;
        // A difference as large as the sum, a zero sum included, gives a ratio of one.
        b2_side_next.rs_full = ds >= ss;
        b2_side_next.rp_full = dp >= sp;
    end

    logic             ds_vld;
    logic [DIV_Q-1:0] qs, qp;
    ray_t             ds_side;

    fdr_div u_div_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (b2_vld_reg),
        .rem_in   (DIV_W'(ds_reg)),
        .low_in   ('0),
        .dvsr_in  (DIV_W'(ss_reg)),
        .side_in  (b2_side_reg),
        .vld_out  (ds_vld),
        .quo_out  (qs),
        .side_out (ds_side)
    );

    fdr_div u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (b2_vld_reg),
        .rem_in   (DIV_W'(dp_reg)),
        .low_in   ('0),
        .dvsr_in  (DIV_W'(sp_reg)),
        .side_in  (b2_side_reg),
        .vld_out  (),
        .quo_out  (qp),
        .side_out ()
    );

    logic             b3_vld_reg, b4_vld_reg;
    logic [SQ_W-1:0]  rs2_reg, rp2_reg;
    ray_t             b3_side_reg;
    res_t             b4_res_reg;
    logic [COS_W-1:0] rs, rp;
    logic [SQ_W:0]    sum;
    logic [REFL_W-1:0] refl_raw;
    res_t             b4_res_next;

    always_comb
    begin
        rs = ds_side.rs_full ? Q30_ONE : COS_W'(qs);
        rp = ds_side.rp_full ? Q30_ONE : COS_W'(qp);
        sum = (SQ_W+1)'(rs2_reg) + (SQ_W+1)'(rp2_reg) + ((SQ_W+1)'(1) << 44);
        refl_raw = sum[SQ_W:45];
        b4_res_next.tir  = b3_side_reg.tir;
        b4_res_next.n1   = b3_side_reg.n1;
        b4_res_next.n2   = b3_side_reg.n2;
        b4_res_next.refl = (b3_side_reg.tir || refl_raw > REFL_ONE) ? REFL_ONE : refl_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= q1_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= d1_vld;
            m4_vld_reg <= m3_vld_reg;
            b1_vld_reg <= q2_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= ds_vld;
            b4_vld_reg <= b3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_num_reg  <= NUM_W'(q1_side.n1) * NUM_W'(sin_i);
            m1_side_reg <= q1_side;
            m2_rem_reg  <= DIV_W'(num_hi);
            m2_low_reg  <= m1_num_reg[DIV_Q-1:0];
            m2_dv_reg   <= DIV_W'(m1_side_reg.n2);
            m2_side_reg <= m2_side_next;
            m3_sq_reg   <= SQ_W'(sin_t) * SQ_W'(sin_t);
            m3_side_reg <= d1_side;
            m4_rad_reg  <= ONE_SQ - RAD_W'(m3_sq_reg);
            m4_side_reg <= m3_side_reg;
            a_reg       <= TERM_W'((NUM_W'(q2_side.n2) * NUM_W'(q2_side.c)) >> 14);
            b_reg       <= TERM_W'((NUM_W'(q2_side.n1) * NUM_W'(cos_t)) >> 14);
            a2_reg      <= TERM_W'((NUM_W'(q2_side.n1) * NUM_W'(q2_side.c)) >> 14);
            b2_reg      <= TERM_W'((NUM_W'(q2_side.n2) * NUM_W'(cos_t)) >> 14);
            b1_side_reg <= q2_side;
            ds_reg      <= ds;
            ss_reg      <= ss;
            dp_reg      <= dp;
            sp_reg      <= sp;
            b2_side_reg <= b2_side_next;
            rs2_reg     <= SQ_W'(rs) * SQ_W'(rs);
            rp2_reg     <= SQ_W'(rp) * SQ_W'(rp);
            b3_side_reg <= ds_side;
            b4_res_reg  <= b4_res_next;
        end
    end

    // Two-entry output buffer between the pipeline and the master side.
    res_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push, pop;
    res_t       head;

    assign push = en && b4_vld_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= b4_res_reg;
        end
    end

    assign head     = buf_reg[rd_ptr_reg];
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {7'd0, head.n2, head.n1, head.refl};
    assign m_tuser  = head.tir;

endmodule

### hw/rtl/fdr_front.sv
// ----------------------------------------------------------------------------
// fdr_front: dot product, index selection and incident cosine radicand
// Five stages: products, sum, sign select and clamp, square, 1 - c^2.
// ----------------------------------------------------------------------------
module fdr_front
    import fdr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_in,
    input  logic signed [15:0]      ix,
    input  logic signed [15:0]      iy,
    input  logic signed [15:0]      iz,
    input  logic signed [15:0]      nx,
    input  logic signed [15:0]      ny,
    input  logic signed [15:0]      nz,
    input  logic [IDX_W-1:0]        outer_index,
    input  logic [IDX_W-1:0]        inner_index,
    output logic                    vld_out,
    output logic [RAD_W-1:0]        rad_out,
    output ray_t                    side_out
);

    logic [4:0]          vld_reg;
    logic signed [31:0]  px_reg, py_reg, pz_reg;
    logic signed [33:0]  dot_reg;
    ray_t                s3_reg, s4_reg, s5_reg;
    logic [SQ_W-1:0]     csq_reg;
    logic [RAD_W-1:0]    rad_reg;

    logic                dot_pos;
    logic signed [33:0]  dot_abs;
    logic [63:0]         mag;
    logic [63:0]         mag_clamped;
    ray_t                s3_next;

    always_comb
    begin
        dot_pos     = dot_reg > 34'sd0;
        dot_abs     = dot_pos ? dot_reg : -dot_reg;
        mag         = 64'($unsigned(dot_abs));
        mag_clamped = (mag > ONE_DOT) ? ONE_DOT : mag;
        s3_next     = '0;
        s3_next.n1  = dot_pos ? inner_index : outer_index;
        s3_next.n2  = dot_pos ? outer_index : inner_index;
        s3_next.c   = COS_W'((mag_clamped >> SH_R) << SH_L);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= ix * nx;
            py_reg  <= iy * ny;
            pz_reg  <= iz * nz;
            dot_reg <= 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
            s3_reg  <= s3_next;
            csq_reg <= SQ_W'(s3_reg.c) * SQ_W'(s3_reg.c);
            s4_reg  <= s3_reg;
            rad_reg <= ONE_SQ - RAD_W'(csq_reg);
            s5_reg  <= s4_reg;
        end
    end

    assign vld_out  = vld_reg[4];
    assign rad_out  = rad_reg;
    assign side_out = s5_reg;

endmodule

### hw/rtl/fdr_isqrt.sv
// ----------------------------------------------------------------------------
// fdr_isqrt: pipelined integer square root
// One result bit per stage, digit by digit from the top of the radicand.
// ----------------------------------------------------------------------------
module fdr_isqrt
    import fdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [RAD_W-1:0]  rad_in,
    input  ray_t              side_in,
    output logic              vld_out,
    output logic [ROOT_W-1:0] root_out,
    output ray_t              side_out
);

    logic              vld_reg  [ISQ_STAGES];
    logic [RAD_W-1:0]  v_reg    [ISQ_STAGES];
    logic [ISQ_RW-1:0] r_reg    [ISQ_STAGES];
    ray_t              side_reg [ISQ_STAGES];

    for (genvar k = 0; k < ISQ_STAGES; k++)
    begin : g_stage
        localparam int SH = RAD_W - 1 - 2 * k;
        localparam logic [ISQ_RW-1:0] BITV = ISQ_RW'(1) << SH;

        logic              vp;
        logic [RAD_W-1:0]  vv;
        logic [ISQ_RW-1:0] rv;
        ray_t              sv;
        logic [ISQ_RW-1:0] trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign vp = vld_in;
            assign vv = rad_in;
            assign rv = '0;
            assign sv = side_in;
        end
        else
        begin : g_rest
            assign vp = vld_reg[k-1];
            assign vv = v_reg[k-1];
            assign rv = r_reg[k-1];
            assign sv = side_reg[k-1];
        end

        assign trial = rv + BITV;
        assign take  = {1'b0, vv} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vp;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= take ? vv - trial[RAD_W-1:0] : vv;
                r_reg[k]    <= take ? (rv >> 1) + BITV : rv >> 1;
                side_reg[k] <= sv;
            end
        end
    end

    assign vld_out  = vld_reg[ISQ_STAGES-1];
    assign root_out = r_reg[ISQ_STAGES-1][ROOT_W-1:0];
    assign side_out = side_reg[ISQ_STAGES-1];

endmodule

### hw/rtl/fdr_div.sv
// ----------------------------------------------------------------------------
// fdr_div: pipelined restoring divider
// The starting remainder must be below the divisor; one quotient bit per stage.
// ----------------------------------------------------------------------------
module fdr_div
    import fdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic [DIV_W-1:0] rem_in,
    input  logic [DIV_Q-1:0] low_in,
    input  logic [DIV_W-1:0] dvsr_in,
    input  ray_t             side_in,
    output logic             vld_out,
    output logic [DIV_Q-1:0] quo_out,
    output ray_t             side_out
);

    logic             vld_reg  [DIV_Q];
    logic [DIV_W-1:0] rem_reg  [DIV_Q];
    logic [DIV_Q-1:0] low_reg  [DIV_Q];
    logic [DIV_W-1:0] dv_reg   [DIV_Q];
    logic [DIV_Q-1:0] q_reg    [DIV_Q];
    ray_t             side_reg [DIV_Q];

    for (genvar k = 0; k < DIV_Q; k++)
    begin : g_stage
        logic             vp;
        logic [DIV_W-1:0] rv;
        logic [DIV_Q-1:0] lv;
        logic [DIV_W-1:0] dv;
        logic [DIV_Q-1:0] qv;
        ray_t             sv;
        logic [DIV_W:0]   cat;
        logic [DIV_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign vp = vld_in;
            assign rv = rem_in;
            assign lv = low_in;
            assign dv = dvsr_in;
            assign qv = '0;
            assign sv = side_in;
        end
        else
        begin : g_rest
            assign vp = vld_reg[k-1];
            assign rv = rem_reg[k-1];
            assign lv = low_reg[k-1];
            assign dv = dv_reg[k-1];
            assign qv = q_reg[k-1];
            assign sv = side_reg[k-1];
        end

        assign cat  = {rv, lv[DIV_Q-1]};
        assign diff = cat - {1'b0, dv};
        assign ge   = cat >= {1'b0, dv};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vp;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DIV_W-1:0] : cat[DIV_W-1:0];
                low_reg[k]  <= lv << 1;
                dv_reg[k]   <= dv;
                q_reg[k]    <= {qv[DIV_Q-2:0], ge};
                side_reg[k] <= sv;
            end
        end
    end

    assign vld_out  = vld_reg[DIV_Q-1];
    assign quo_out  = q_reg[DIV_Q-1];
    assign side_out = side_reg[DIV_Q-1];

endmodule

### hw/rtl/fdr_checker.sv
// ----------------------------------------------------------------------------
// fdr_checker: port-level checks of the Fresnel reflectance block
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module fdr_checker
    import fdr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result transaction keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Total internal reflection always reports a reflectance of one.
    a_tir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[16:0] == 17'd65536)
        else $error("TIR result without unit reflectance");

    // Reflectance never exceeds one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:0] <= 17'd65536)
        else $error("reflectance above one");

    // The input side only stalls when results are waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind fresnel_dielectric_reflectance_top fdr_checker u_fdr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
